// ----- design/first_fit_pool_allocator_defines.svh -----
// Assertion macros used by the allocator RTL.
`ifndef FIRST_FIT_POOL_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_POOL_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/fpa_pkg.sv -----
`default_nettype none

package fpa_pkg;

   localparam int ADDR_W = 12;
   localparam int SIZE_W = 16;
   localparam int STATUS_W = 2;
   localparam int NEED_W = 14;
   localparam int OFF_W = 18;
   localparam int TGT_W = 9;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

endpackage

`default_nettype wire

// ----- design/fpa_hdr_ram.sv -----
`default_nettype none

module fpa_hdr_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 12,
   parameter int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- design/first_fit_pool_allocator.sv -----
// First-fit pool allocator. The pool is kept as a chain of blocks in address
// order, each a header followed by a payload, and the headers live in one
// synchronous memory with one entry per 8-byte granule. After reset the block
// writes the initial free block and then accepts requests. A request walks the
// chain from the start of the pool, and each block it visits is first read from
// the memory (S_READ) and then has its header examined (S_EVAL). A free that
// meets a following block also reads that block's header (S_NXRD, S_NXEV), and
// the header updates take one or two writes (S_WR1, S_WR2). A request visits at
// most POOL_BYTES / (header size + 8) blocks. A new request is taken while the
// previous response still waits on the response channel.
`default_nettype none

`include "first_fit_pool_allocator_defines.svh"

module first_fit_pool_allocator
   import fpa_pkg::*;
#(
   parameter int POOL_BYTES = 4096,
   parameter int HEADER_BYTES = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_op,
   input  wire logic [SIZE_W-1:0]   req_size,
   input  wire logic [ADDR_W-1:0]   req_free_addr,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [ADDR_W-1:0]   rsp_addr,
   output logic      [STATUS_W-1:0] rsp_status
);

   localparam int GRANULES = POOL_BYTES / 8;
   localparam int HDR_G = (HEADER_BYTES + 7) / 8;
   localparam int HDR = HDR_G * 8;
   localparam int GW = $clog2(GRANULES + 1);
   localparam int IW = $clog2(GRANULES);
   localparam int EW = GW + 2;

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_READ = 4'd2;
   localparam logic [3:0] S_EVAL = 4'd3;
   localparam logic [3:0] S_NXRD = 4'd4;
   localparam logic [3:0] S_NXEV = 4'd5;
   localparam logic [3:0] S_WR1 = 4'd6;
   localparam logic [3:0] S_WR2 = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic                op_ff, op_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic [TGT_W-1:0]    target_ff, target_in;
   logic [GW-1:0]       cur_ff, cur_in;
   logic [GW-1:0]       prev_ff, prev_in;
   logic [GW-1:0]       prev_size_ff, prev_size_in;
   logic                prev_free_ff, prev_free_in;
   logic                has_prev_ff, has_prev_in;
   logic [GW-1:0]       bsize_ff, bsize_in;
   logic [IW-1:0]       wa1_ff, wa1_in;
   logic [EW-1:0]       wd1_ff, wd1_in;
   logic [IW-1:0]       wa2_ff, wa2_in;
   logic [EW-1:0]       wd2_ff, wd2_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                ram_we;
   logic [IW-1:0]       ram_waddr;
   logic [EW-1:0]       ram_wdata;
   logic [IW-1:0]       ram_raddr;
   logic [EW-1:0]       ram_rdata;

   fpa_hdr_ram #(
      .DEPTH(GRANULES),
      .WIDTH(EW),
      .AW(IW)
   ) u_hdr_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      ram_we = 1'b0;
      ram_waddr = wa2_ff;
      ram_wdata = wd2_ff;
      ram_raddr = cur_ff[IW-1:0];
      case (state_ff)
         S_INIT: begin
            ram_we = 1'b1;
            ram_waddr = '0;
            ram_wdata = {1'b1, 1'b1, GW'(GRANULES - HDR_G)};
         end
         S_WR1: begin
            ram_we = 1'b1;
            ram_waddr = wa1_ff;
            ram_wdata = wd1_ff;
         end
         S_WR2: begin
            ram_we = 1'b1;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      logic                rd_start;
      logic                rd_free;
      logic [GW-1:0]       rd_size;
      logic [GW-1:0]       next_g;
      logic [NEED_W:0]     size_x;
      logic [NEED_W:0]     need_x;
      logic [NEED_W:0]     rest_x;
      logic [OFF_W-1:0]    cur_off;
      logic [OFF_W-1:0]    tgt_off;
      logic [SIZE_W:0]     size_round;
      logic [ADDR_W-1:0]   tgt_byte;
      logic                go_free_wr;
      logic [GW-1:0]       merged;

      rd_start = ram_rdata[EW-1];
      rd_free = ram_rdata[EW-2];
      rd_size = ram_rdata[GW-1:0];
      next_g = cur_ff + GW'(HDR_G) + rd_size;
      size_x = (NEED_W + 1)'(rd_size);
      need_x = (NEED_W + 1)'(need_ff);
      rest_x = (NEED_W + 1)'(cur_ff) + (NEED_W + 1)'(HDR_G) + need_x;
      cur_off = OFF_W'(cur_ff);
      tgt_off = OFF_W'(target_ff);
      size_round = (SIZE_W + 1)'(req_size) + (SIZE_W + 1)'(7);
      tgt_byte = req_free_addr - ADDR_W'(HDR);
      go_free_wr = 1'b0;
      merged = bsize_ff;

      state_in = state_ff;
      op_in = op_ff;
      need_in = need_ff;
      target_in = target_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      prev_size_in = prev_size_ff;
      prev_free_in = prev_free_ff;
      has_prev_in = has_prev_ff;
      bsize_in = bsize_ff;
      wa1_in = wa1_ff;
      wd1_in = wd1_ff;
      wa2_in = wa2_ff;
      wd2_in = wd2_ff;
      res_addr_in = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_addr_in = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_INIT: begin
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               cur_in = '0;
               has_prev_in = 1'b0;
               res_addr_in = '0;
               need_in = size_round[SIZE_W:3];
               target_in = tgt_byte[ADDR_W-1:3];
               if (req_op == OP_ALLOC) begin
                  if (req_size == '0 ||
                      (SIZE_W + 1)'(req_size) > (SIZE_W + 1)'(POOL_BYTES)) begin
                     res_status_in = ST_ALLOC_FAIL;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end else if (req_free_addr == '0) begin
                  res_status_in = ST_OK;
                  state_in = S_DONE;
               end else if (OFF_W'(req_free_addr) < OFF_W'(HDR) ||
                            req_free_addr[2:0] != 3'd0) begin
                  res_status_in = ST_BAD_FREE;
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            if (cur_ff >= GW'(GRANULES)) begin
               res_status_in = (op_ff == OP_ALLOC) ? ST_ALLOC_FAIL : ST_BAD_FREE;
               state_in = S_DONE;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!rd_start) begin
               res_status_in = (op_ff == OP_ALLOC) ? ST_ALLOC_FAIL : ST_BAD_FREE;
               state_in = S_DONE;
            end else if (op_ff == OP_ALLOC) begin
               if (rd_free && size_x >= need_x) begin
                  res_addr_in = ADDR_W'((cur_off << 3) + OFF_W'(HDR));
                  res_status_in = ST_OK;
                  wa2_in = cur_ff[IW-1:0];
                  if (size_x >= need_x + (NEED_W + 1)'(HDR_G + 1)) begin
                     wa1_in = rest_x[IW-1:0];
                     wd1_in = {1'b1, 1'b1, rd_size - GW'(need_ff) - GW'(HDR_G)};
                     wd2_in = {1'b1, 1'b0, GW'(need_ff)};
                     state_in = S_WR1;
                  end else begin
                     wd2_in = {1'b1, 1'b0, rd_size};
                     state_in = S_WR2;
                  end
               end else begin
                  cur_in = next_g;
                  state_in = S_READ;
               end
            end else if (cur_off == tgt_off) begin
               bsize_in = rd_size;
               merged = rd_size;
               if (next_g < GW'(GRANULES)) begin
                  cur_in = next_g;
                  state_in = S_NXRD;
               end else begin
                  go_free_wr = 1'b1;
               end
            end else if (cur_off > tgt_off) begin
               res_status_in = ST_BAD_FREE;
               state_in = S_DONE;
            end else begin
               prev_in = cur_ff;
               prev_free_in = rd_free;
               prev_size_in = rd_size;
               has_prev_in = 1'b1;
               cur_in = next_g;
               state_in = S_READ;
            end
         end
         S_NXRD: begin
            state_in = S_NXEV;
         end
         S_NXEV: begin
            if (rd_start && rd_free) begin
               merged = bsize_ff + GW'(HDR_G) + rd_size;
            end
            go_free_wr = 1'b1;
         end
         S_WR1: begin
            state_in = S_WR2;
         end
         S_WR2: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (go_free_wr) begin
         res_status_in = ST_OK;
         if (has_prev_ff && prev_free_ff) begin
            wa2_in = prev_ff[IW-1:0];
            wd2_in = {1'b1, 1'b1, prev_size_ff + GW'(HDR_G) + merged};
         end else begin
            wa2_in = GW'(target_ff) < GW'(GRANULES) ? IW'(target_ff) : '0;
            wd2_in = {1'b1, 1'b1, merged};
         end
         state_in = S_WR2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      need_ff <= need_in;
      target_ff <= target_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      prev_size_ff <= prev_size_in;
      prev_free_ff <= prev_free_in;
      has_prev_ff <= has_prev_in;
      bsize_ff <= bsize_in;
      wa1_ff <= wa1_in;
      wd1_ff <= wd1_in;
      wa2_ff <= wa2_in;
      wd2_ff <= wd2_in;
      res_addr_ff <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_addr = rsp_addr_ff;
   assign rsp_status = rsp_status_ff;

   `FPA_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, state_ff != S_IDLE, "Request accepted but the allocator stayed idle.")
   `FPA_ASSERT_IMP(a_fail_addr_zero, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_addr_ff == '0, "A failed response carries a nonzero address.")
   `FPA_ASSERT_IMP(a_eval_in_pool, clock, reset, state_ff == S_EVAL, cur_ff < GW'(GRANULES), "Header examined beyond the end of the pool.")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top
   import fpa_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned POOL = 4096;
   localparam int unsigned HDR = (24 + 7) / 8 * 8;
   localparam int unsigned USED = POOL / 8 * 8;
   localparam int unsigned GRAN = USED / 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 300;
   localparam int RANDOM_PER_PHASE = 150;

   typedef struct packed {
      logic              op;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
   } pool_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   addr;
      logic [STATUS_W-1:0] status;
   } pool_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_op = OP_ALLOC;
   logic [SIZE_W-1:0]   req_size = '0;
   logic [ADDR_W-1:0]   req_free_addr = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ADDR_W-1:0]   rsp_addr;
   logic [STATUS_W-1:0] rsp_status;

   pool_req_type pending_reqs[$];
   pool_rsp_type predicted_rsps[$];
   logic [ADDR_W-1:0] live_ptrs[$];
   logic [ADDR_W-1:0] old_ptrs[$];

   bit          blk_start[GRAN];
   bit          blk_free[GRAN];
   int unsigned blk_size[GRAN];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  queued_cnt = 0;
   int  accepted_cnt = 0;
   int  rsp_cnt = 0;
   int  errors = 0;
   int  cycle_cnt = 0;
   bit  hold_go = 1'b0;
   bit  rsp_hold = 1'b0;

   first_fit_pool_allocator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_size      (req_size),
      .req_free_addr (req_free_addr),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_addr      (rsp_addr),
      .rsp_status    (rsp_status)
   );

   always #5 clock = ~clock;

   function automatic bit is_blk(int unsigned off);
      return off < USED && blk_start[off / 8];
   endfunction

   function automatic int unsigned after(int unsigned off);
      return off + HDR + blk_size[off / 8];
   endfunction

   function automatic void forget_ptr(logic [ADDR_W-1:0] p);
      for (int i = 0; i < live_ptrs.size(); i++) begin
         if (live_ptrs[i] == p) begin
            live_ptrs.delete(i);
            break;
         end
      end
      old_ptrs.push_back(p);
   endfunction

   function automatic pool_rsp_type pool_respond(pool_req_type rq);
      pool_rsp_type r;
      int unsigned  n, need, cur, prev, target, nx, rest, guard, tg;
      bit           has_prev, found, done;
      r.addr = '0;
      r.status = ST_OK;
      if (rq.op == OP_ALLOC) begin
         r.status = ST_ALLOC_FAIL;
         n = rq.size;
         if (n != 0 && n <= POOL) begin
            need = (n + 7) / 8 * 8;
            cur = 0;
            guard = 0;
            done = 1'b0;
            while (is_blk(cur) && guard <= GRAN && !done) begin
               if (blk_free[cur / 8] && blk_size[cur / 8] >= need) begin
                  if (blk_size[cur / 8] >= need + HDR + 8) begin
                     rest = (cur + HDR + need) / 8;
                     blk_start[rest] = 1'b1;
                     blk_free[rest] = 1'b1;
                     blk_size[rest] = blk_size[cur / 8] - need - HDR;
                     blk_size[cur / 8] = need;
                  end
                  blk_free[cur / 8] = 1'b0;
                  r.addr = ADDR_W'(cur + HDR);
                  r.status = ST_OK;
                  live_ptrs.push_back(r.addr);
                  done = 1'b1;
               end else begin
                  cur = after(cur);
                  guard++;
               end
            end
         end
      end else if (rq.addr != '0) begin
         r.status = ST_BAD_FREE;
         if (rq.addr >= HDR) begin
            target = rq.addr - HDR;
            cur = 0;
            prev = 0;
            has_prev = 1'b0;
            guard = 0;
            while (is_blk(cur) && guard <= GRAN && cur < target) begin
               prev = cur;
               has_prev = 1'b1;
               cur = after(cur);
               guard++;
            end
            found = is_blk(cur) && guard <= GRAN && cur == target;
            if (found) begin
               tg = target / 8;
               nx = after(target);
               blk_free[tg] = 1'b1;
               if (is_blk(nx) && blk_free[nx / 8]) begin
                  blk_size[tg] += HDR + blk_size[nx / 8];
                  blk_start[nx / 8] = 1'b0;
                  blk_free[nx / 8] = 1'b0;
                  blk_size[nx / 8] = 0;
               end
               if (has_prev && blk_free[prev / 8]) begin
                  blk_size[prev / 8] += HDR + blk_size[tg];
                  blk_start[tg] = 1'b0;
                  blk_free[tg] = 1'b0;
                  blk_size[tg] = 0;
               end
               r.status = ST_OK;
               forget_ptr(rq.addr);
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      if (errors < 100) $display("mismatch at response %0d: %s", rsp_cnt, msg);
      errors++;
   endtask

   task automatic push_req(logic op, int unsigned size, int unsigned addr);
      pool_req_type rq;
      rq.op = op;
      rq.size = SIZE_W'(size);
      rq.addr = ADDR_W'(addr);
      pending_reqs.push_back(rq);
      queued_cnt++;
   endtask

   task automatic queue_batch(int count);
      int k, free_pct;
      repeat (count) begin
         k = $urandom_range(99);
         if (live_ptrs.size() > 12) free_pct = 65;
         else if (live_ptrs.size() == 0) free_pct = 20;
         else free_pct = 40;
         if (k < free_pct) begin
            k = $urandom_range(99);
            if (k < 70 && live_ptrs.size() != 0)
               push_req(OP_FREE, $urandom_range(65535),
                        live_ptrs[$urandom_range(live_ptrs.size() - 1)]);
            else if (k < 85 && old_ptrs.size() != 0)
               push_req(OP_FREE, $urandom_range(65535),
                        old_ptrs[$urandom_range(old_ptrs.size() - 1)]);
            else if (k < 95)
               push_req(OP_FREE, $urandom_range(65535), $urandom_range(4095));
            else
               push_req(OP_FREE, $urandom_range(65535), 0);
         end else begin
            k = $urandom_range(99);
            if (k < 60) push_req(OP_ALLOC, $urandom_range(64, 1), $urandom_range(4095));
            else if (k < 85) push_req(OP_ALLOC, $urandom_range(512, 1), $urandom_range(4095));
            else if (k < 95) push_req(OP_ALLOC, $urandom_range(4096, 1), $urandom_range(4095));
            else push_req(OP_ALLOC, $urandom_range(65535), $urandom_range(4095));
         end
      end
   endtask

   task automatic wait_accepted();
      while (accepted_cnt != queued_cnt) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (accepted_cnt != queued_cnt || predicted_rsps.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin : drive_reqs
      pool_req_type cur_req;
      pool_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            cur_req.op = req_op;
            cur_req.size = req_size;
            cur_req.addr = req_free_addr;
            predicted_rsps.push_back(pool_respond(cur_req));
            accepted_cnt <= accepted_cnt + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_op <= nxt.op;
               req_size <= nxt.size;
               req_free_addr <= nxt.addr;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsps
      pool_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected response addr %0d status %0d",
                                         rsp_addr, rsp_status));
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_addr !== want.addr)
                  report_mismatch($sformatf("addr %0d, expected %0d", rsp_addr, want.addr));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
            end
            rsp_cnt++;
         end
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      wait (hold_go);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      int left;
      for (int g = 0; g < GRAN; g++) begin
         blk_start[g] = 1'b0;
         blk_free[g] = 1'b0;
         blk_size[g] = 0;
      end
      blk_start[0] = 1'b1;
      blk_free[0] = 1'b1;
      blk_size[0] = USED - HDR;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 38;
      recv_idle_pct = 71;
      push_req(OP_ALLOC, 0, 12'hFFF);
      push_req(OP_ALLOC, 4097, 0);
      push_req(OP_ALLOC, 65535, 0);
      push_req(OP_ALLOC, 4096, 0);
      push_req(OP_FREE, 65535, 0);
      push_req(OP_FREE, 0, 4095);
      push_req(OP_FREE, 0, 23);
      push_req(OP_FREE, 0, 24);
      push_req(OP_ALLOC, 4072, 0);
      push_req(OP_ALLOC, 1, 0);
      push_req(OP_FREE, 0, 24);
      push_req(OP_ALLOC, 1, 0);
      push_req(OP_ALLOC, 8, 0);
      push_req(OP_ALLOC, 9, 0);
      push_req(OP_ALLOC, 4000, 0);
      push_req(OP_FREE, 0, 56);
      push_req(OP_FREE, 0, 56);
      push_req(OP_FREE, 0, 24);
      push_req(OP_FREE, 0, 60);
      push_req(OP_ALLOC, 40, 0);
      push_req(OP_ALLOC, 32768, 0);
      push_req(OP_FREE, 65535, 4095);
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         left = RANDOM_PER_PHASE;
         if (ph == 2) begin
            hold_go = 1'b1;
            queue_batch(24);
            left -= 24;
         end
         while (left > 0) begin
            queue_batch(6);
            left -= 6;
            wait_accepted();
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (errors == 0 && predicted_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- first_fit_pool_allocator.f -----
+incdir+design
design/fpa_pkg.sv
design/fpa_hdr_ram.sv
design/first_fit_pool_allocator.sv
bench/tb_top.sv
